// ===== hdl/vertex_attribute_unifier_assert.svh =====
// Assertion macros used by the checker file.
`ifndef VERTEX_ATTRIBUTE_UNIFIER_ASSERT_SVH
`define VERTEX_ATTRIBUTE_UNIFIER_ASSERT_SVH

// Check a consequence in the same cycle as its condition.
`define VAU_ASSERT_NOW(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);

// Check a consequence in the cycle after its condition.
`define VAU_ASSERT_NEXT(name, pre, post, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

// ===== hdl/vau_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package vau_pkg;

    localparam int MAX_POINTS_DEF = 4096;
    localparam int ENTRIES_DEF    = 8;
    localparam int EPOCH_W        = 8;

    localparam logic [23:0] VERTEX_MAX    = 24'hFFFFFF;
    localparam logic [15:0] UV_TOL_RESET  = 16'd655;

    // One remap slot as stored in the row memory
    typedef struct packed {
        logic        [23:0] vertex;
        logic        [15:0] normal;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } slot_t;

    // Lookup result of one row
    typedef struct packed {
        logic  hit;
        slot_t slot;
    } match_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_LOOKUP
    } state_t;

    // Strict per-axis tolerance test: |a - b| < tol
    function automatic logic within_tol(
        input logic signed [31:0] a,
        input logic signed [31:0] b,
        input logic        [15:0] tol
    );
        logic signed [33:0] d;
        logic signed [33:0] t;
        d = 34'(a) - 34'(b);
        t = $signed({18'd0, tol});
        return (d < t) && (d > -t);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/vau_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Corner channel
interface vau_in_if;
    logic               valid;
    logic               ready;
    logic        [11:0] point_index;
    logic        [15:0] normal_index;
    logic signed [31:0] tex_u;
    logic signed [31:0] tex_v;
    logic               new_mesh;

    modport source (output valid, point_index, normal_index, tex_u, tex_v, new_mesh,
                    input ready);
    modport sink   (input valid, point_index, normal_index, tex_u, tex_v, new_mesh,
                    output ready);
endinterface

// Vertex result channel
interface vau_out_if;
    logic               valid;
    logic               ready;
    logic        [23:0] vertex_index;
    logic               is_new;
    logic        [11:0] source_point;
    logic        [15:0] source_normal;
    logic signed [31:0] out_u;
    logic signed [31:0] out_v;

    modport source (output valid, vertex_index, is_new, source_point, source_normal,
                    out_u, out_v, input ready);
    modport sink   (input valid, vertex_index, is_new, source_point, source_normal,
                    out_u, out_v, output ready);
endinterface

// Tolerance register write channel
interface vau_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] tolerance;

    modport source (output valid, tolerance, input ready);
    modport sink   (input valid, tolerance, output ready);
endinterface

`default_nettype wire

// ===== hdl/vau_row_match.sv =====
`timescale 1ns / 1ps
`default_nettype none

module vau_row_match #(
    parameter int ENTRIES = vau_pkg::ENTRIES_DEF
) (
    input  vau_pkg::slot_t [ENTRIES-1:0]            row,
    input  logic [$clog2(ENTRIES + 1)-1:0]          count,
    input  logic        [15:0]                      normal,
    input  logic signed [31:0]                      u,
    input  logic signed [31:0]                      v,
    input  logic        [15:0]                      tol,
    output vau_pkg::match_t                         result
);

    localparam int CW = $clog2(ENTRIES + 1);

    // Compare every filled slot in parallel; the lowest matching slot wins
    always_comb
    begin
        result = '0;
        for (int j = ENTRIES - 1; j >= 0; j--)
        begin
            if ((CW'(j) < count) && (row[j].normal == normal) &&
                vau_pkg::within_tol(row[j].u, u, tol) &&
                vau_pkg::within_tol(row[j].v, v, tol))
            begin
                result.hit  = 1'b1;
                result.slot = row[j];
            end
        end
    end

endmodule

`default_nettype wire

// ===== hdl/vertex_attribute_unifier.sv =====
// A corner's row is read into registers at acceptance (again after a clearing pass), then
//   compared, written back and its vertex item registered before another corner is taken;
//   while a vertex item stalls, the next lookup waits and no further corner is taken.
// Reset: tolerance 655, vertex counter 0, then a clearing pass over every row of
//   the fill-count memory; the same pass runs on every 256th new_mesh corner.
`timescale 1ns / 1ps
`default_nettype none

module vertex_attribute_unifier #(
    parameter int MAX_POINTS = vau_pkg::MAX_POINTS_DEF,
    parameter int ENTRIES    = vau_pkg::ENTRIES_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    vau_in_if.sink        corner,
    vau_out_if.source     vertex,
    vau_cfg_if.sink       cfg
);

    localparam int AW = (MAX_POINTS > 1) ? $clog2(MAX_POINTS) : 1;
    localparam int CW = $clog2(ENTRIES + 1);
    localparam int IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int EW = vau_pkg::EPOCH_W;

    localparam logic [16:0]   PointLimit = 17'(MAX_POINTS);
    localparam logic [AW-1:0] LastRow    = AW'(MAX_POINTS - 1);
    localparam logic [CW-1:0] FullCount  = CW'(ENTRIES);
    localparam logic [EW-1:0] EpochLast  = '1;

    typedef struct packed {
        logic [EW-1:0] tag;
        logic [CW-1:0] count;
    } meta_t;

    typedef vau_pkg::slot_t [ENTRIES-1:0] row_t;

    // Row memory holds the slots, meta memory the epoch tag and fill count
    row_t  row_mem  [MAX_POINTS];
    meta_t meta_mem [MAX_POINTS];
    row_t  row_rd_reg;
    meta_t meta_rd_reg;

    vau_pkg::state_t state_reg, state_next;
    logic [15:0]     tol_reg;
    logic [EW-1:0]   epoch_reg, epoch_next;
    logic [23:0]     vcount_reg;
    logic [AW-1:0]   clr_reg, clr_next;
    logic            pend_reg, pend_next;

    logic        [11:0] point_reg;
    logic        [15:0] normal_reg;
    logic signed [31:0] u_reg;
    logic signed [31:0] v_reg;

    logic               out_valid_reg;
    logic        [23:0] out_index_reg;
    logic               out_new_reg;
    logic        [11:0] out_point_reg;
    logic        [15:0] out_normal_reg;
    logic signed [31:0] out_u_reg;
    logic signed [31:0] out_v_reg;

    logic            in_acc;
    logic            wrap;
    logic            rd_en;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   item_addr;
    logic            in_range;
    logic [CW-1:0]   cur_count;
    logic            room;
    logic            fire;
    logic            record;
    logic            meta_we;
    logic [AW-1:0]   meta_waddr;
    meta_t           meta_wdata;
    row_t            row_wr;
    vau_pkg::slot_t  new_slot;
    vau_pkg::match_t match;

    assign in_acc    = corner.valid && corner.ready;
    assign wrap      = in_acc && corner.new_mesh && (epoch_reg == EpochLast);
    assign item_addr = AW'(point_reg);

    // Read at acceptance, or again after a clearing pass
    assign rd_en   = in_acc || (state_reg == vau_pkg::ST_READ);
    assign rd_addr = (state_reg == vau_pkg::ST_READ) ? item_addr : AW'(corner.point_index);

    // Rows of an older epoch count as empty
    assign in_range  = 17'(point_reg) < PointLimit;
    assign cur_count = (in_range && (meta_rd_reg.tag == epoch_reg)) ? meta_rd_reg.count : '0;
    assign room      = in_range && (cur_count < FullCount);

    vau_row_match #(
        .ENTRIES (ENTRIES)
    ) u_match (
        .row    (row_rd_reg),
        .count  (cur_count),
        .normal (normal_reg),
        .u      (u_reg),
        .v      (v_reg),
        .tol    (tol_reg),
        .result (match)
    );

    assign fire   = (state_reg == vau_pkg::ST_LOOKUP) && (!out_valid_reg || vertex.ready);
    assign record = fire && !match.hit && room;

    // Build the written-back row with the new slot at the fill position
    always_comb
    begin
        new_slot.vertex = vcount_reg;
        new_slot.normal = normal_reg;
        new_slot.u      = u_reg;
        new_slot.v      = v_reg;
        row_wr          = row_rd_reg;
        row_wr[IW'(cur_count)] = new_slot;
    end

    // Meta write: clearing pass or fill-count update
    always_comb
    begin
        if (state_reg == vau_pkg::ST_CLEAR)
        begin
            meta_we    = 1'b1;
            meta_waddr = clr_reg;
            meta_wdata = '0;
        end
        else
        begin
            meta_we          = record;
            meta_waddr       = item_addr;
            meta_wdata.tag   = epoch_reg;
            meta_wdata.count = cur_count + CW'(1);
        end
    end

    // Memories; write-back and the next read never share a cycle
    always_ff @(posedge clk)
    begin
        if (meta_we)
        begin
            meta_mem[meta_waddr] <= meta_wdata;
        end
        if (record)
        begin
            row_mem[item_addr] <= row_wr;
        end
        if (rd_en)
        begin
            meta_rd_reg <= meta_mem[rd_addr];
            row_rd_reg  <= row_mem[rd_addr];
        end
    end

    // Next state, epoch and clearing address
    always_comb
    begin
        state_next = state_reg;
        epoch_next = epoch_reg;
        clr_next   = clr_reg;
        pend_next  = pend_reg;
        unique case (state_reg)
            vau_pkg::ST_CLEAR:
            begin
                if (clr_reg == LastRow)
                begin
                    clr_next   = '0;
                    pend_next  = 1'b0;
                    state_next = pend_reg ? vau_pkg::ST_READ : vau_pkg::ST_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + AW'(1);
                end
            end
            vau_pkg::ST_IDLE:
            begin
                if (in_acc)
                begin
                    if (wrap)
                    begin
                        epoch_next = '0;
                        pend_next  = 1'b1;
                        state_next = vau_pkg::ST_CLEAR;
                    end
                    else
                    begin
                        if (corner.new_mesh)
                        begin
                            epoch_next = epoch_reg + EW'(1);
                        end
                        state_next = vau_pkg::ST_LOOKUP;
                    end
                end
            end
            vau_pkg::ST_READ:
            begin
                state_next = vau_pkg::ST_LOOKUP;
            end
            vau_pkg::ST_LOOKUP:
            begin
                if (fire)
                begin
                    state_next = vau_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vau_pkg::ST_CLEAR;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= vau_pkg::ST_CLEAR;
            epoch_reg     <= '0;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            tol_reg       <= vau_pkg::UV_TOL_RESET;
            vcount_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            epoch_reg <= epoch_next;
            clr_reg   <= clr_next;
            pend_reg  <= pend_next;
            if (cfg.valid && cfg.ready)
            begin
                tol_reg <= cfg.tolerance;
            end
            // Advance the vertex counter on every new vertex, saturating
            if (fire && !match.hit && (vcount_reg != vau_pkg::VERTEX_MAX))
            begin
                vcount_reg <= vcount_reg + 24'd1;
            end
            if (fire)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (vertex.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Hold the accepted corner and the output item
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            point_reg  <= corner.point_index;
            normal_reg <= corner.normal_index;
            u_reg      <= corner.tex_u;
            v_reg      <= corner.tex_v;
        end
        if (fire)
        begin
            out_index_reg  <= match.hit ? match.slot.vertex : vcount_reg;
            out_new_reg    <= !match.hit;
            out_point_reg  <= point_reg;
            out_normal_reg <= match.hit ? match.slot.normal : normal_reg;
            out_u_reg      <= match.hit ? match.slot.u : u_reg;
            out_v_reg      <= match.hit ? match.slot.v : v_reg;
        end
    end

    assign corner.ready        = (state_reg == vau_pkg::ST_IDLE);
    assign cfg.ready           = 1'b1;
    assign vertex.valid        = out_valid_reg;
    assign vertex.vertex_index = out_index_reg;
    assign vertex.is_new       = out_new_reg;
    assign vertex.source_point = out_point_reg;
    assign vertex.source_normal = out_normal_reg;
    assign vertex.out_u        = out_u_reg;
    assign vertex.out_v        = out_v_reg;

endmodule

`default_nettype wire

// ===== hdl/vau_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
`include "vertex_attribute_unifier_assert.svh"

module vau_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        c_valid,
    input logic        c_ready,
    input logic        v_valid,
    input logic        v_ready,
    input logic [23:0] v_index,
    input logic        v_new
);

    logic [1:0]  pend_reg, pend_next;
    logic [23:0] nxt_reg, nxt_next;
    logic        c_acc;
    logic        v_acc;

    assign c_acc = c_valid && c_ready;
    assign v_acc = v_valid && v_ready;

    // Track corners in flight and the number the next new vertex must carry
    always_comb
    begin
        pend_next = pend_reg + 2'(c_acc) - 2'(v_acc);
        nxt_next  = nxt_reg;
        if (v_acc && v_new && (nxt_reg != 24'hFFFFFF))
        begin
            nxt_next = nxt_reg + 24'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
            nxt_reg  <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
            nxt_reg  <= nxt_next;
        end
    end

    `VAU_ASSERT_NEXT(a_out_hold, v_valid && !v_ready, v_valid, "vertex item dropped while stalled")
    `VAU_ASSERT_NOW(a_no_extra, v_valid, pend_reg != 2'd0, "vertex item without a corner")
    `VAU_ASSERT_NOW(a_new_order, v_valid && v_new, v_index == nxt_reg, "new vertex out of order")
    `VAU_ASSERT_NOW(a_reuse_known, v_valid && !v_new, (v_index < nxt_reg) || (nxt_reg == 24'hFFFFFF), "reused vertex never issued")

endmodule

bind vertex_attribute_unifier vau_checker u_vau_checker (
    .clk     (clk),
    .rst_n   (rst_n),
    .c_valid (corner.valid),
    .c_ready (corner.ready),
    .v_valid (vertex.valid),
    .v_ready (vertex.ready),
    .v_index (vertex.vertex_index),
    .v_new   (vertex.is_new)
);

`default_nettype wire

// ===== tb/vertex_attribute_unifier_tb.sv =====
`timescale 1ns / 1ps

module vertex_attribute_unifier_tb;

    localparam int NUM_POINTS  = vau_pkg::MAX_POINTS_DEF;
    localparam int SLOTS_PER   = vau_pkg::ENTRIES_DEF;
    localparam int SLOT_TOTAL  = NUM_POINTS * SLOTS_PER;
    localparam int POOL        = 6;
    localparam int PHASES      = 6;
    localparam int PHASE_ITEMS = 222;
    localparam int STALL_LIMIT = 20000;

    typedef struct packed {
        logic        [11:0] point;
        logic        [15:0] normal;
        logic signed [31:0] u;
        logic signed [31:0] v;
        logic               new_mesh;
    } corner_t;

    typedef struct packed {
        logic        [23:0] index;
        logic               is_new;
        logic        [11:0] point;
        logic        [15:0] normal;
        logic signed [31:0] u;
        logic signed [31:0] v;
    } vertex_t;

    logic clk;
    logic rst_n;

    vau_in_if  corner_if ();
    vau_out_if vertex_if ();
    vau_cfg_if cfg_if ();

    vertex_attribute_unifier u_top (
        .clk    (clk),
        .rst_n  (rst_n),
        .corner (corner_if),
        .vertex (vertex_if),
        .cfg    (cfg_if)
    );

    // Remap state mirror; a slot is live when its mesh tag equals the current mesh
    int unsigned        slot_mesh [SLOT_TOTAL];
    logic        [23:0] slot_vtx  [SLOT_TOTAL];
    logic        [15:0] slot_nrm  [SLOT_TOTAL];
    logic signed [31:0] slot_u    [SLOT_TOTAL];
    logic signed [31:0] slot_v    [SLOT_TOTAL];
    int unsigned        mesh_id = 1;
    logic        [23:0] next_vertex = '0;
    int                 tol_reg = int'(vau_pkg::UV_TOL_RESET);

    corner_t corner_queue[$];
    vertex_t expected_vertices[$];

    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int corners_queued = 0;
    int corners_accepted = 0;
    int error_count = 0;
    int stall_cycles = 0;
    int n_recorded = 0;
    int n_reused = 0;
    int n_unrecorded = 0;
    int n_mesh = 0;

    logic        [11:0] pool_point  [POOL];
    logic        [15:0] pool_normal [POOL];
    logic signed [31:0] pool_u      [POOL];
    logic signed [31:0] pool_v      [POOL];

    function automatic bit close_enough(logic signed [31:0] a, logic signed [31:0] b);
        longint d;
        d = longint'(a) - longint'(b);
        if (d < 0)
            d = -d;
        return d < longint'(tol_reg);
    endfunction

    function automatic logic [23:0] issue_vertex();
        logic [23:0] n;
        n = next_vertex;
        if (next_vertex != vau_pkg::VERTEX_MAX)
            next_vertex = next_vertex + 24'd1;
        return n;
    endfunction

    // Unify one corner against the slot mirror and return its vertex item
    function automatic vertex_t unify_corner(corner_t c);
        vertex_t r;
        int      s;
        int      j;
        bit      done;
        r.index  = '0;
        r.is_new = 1'b1;
        r.point  = c.point;
        r.normal = c.normal;
        r.u      = c.u;
        r.v      = c.v;
        done     = 1'b0;
        if (c.new_mesh)
        begin
            mesh_id++;
            n_mesh++;
        end
        if (c.point < NUM_POINTS)
        begin
            for (j = 0; j < SLOTS_PER && !done; j++)
            begin
                s = c.point * SLOTS_PER + j;
                if (slot_mesh[s] != mesh_id)
                begin
                    r.index      = issue_vertex();
                    slot_mesh[s] = mesh_id;
                    slot_vtx[s]  = r.index;
                    slot_nrm[s]  = c.normal;
                    slot_u[s]    = c.u;
                    slot_v[s]    = c.v;
                    done         = 1'b1;
                    n_recorded++;
                end
                else if (slot_nrm[s] == c.normal && close_enough(slot_u[s], c.u)
                         && close_enough(slot_v[s], c.v))
                begin
                    r.index  = slot_vtx[s];
                    r.is_new = 1'b0;
                    r.normal = slot_nrm[s];
                    r.u      = slot_u[s];
                    r.v      = slot_v[s];
                    done     = 1'b1;
                    n_reused++;
                end
            end
        end
        if (!done)
        begin
            r.index = issue_vertex();
            n_unrecorded++;
        end
        return r;
    endfunction

    function automatic void push_corner(logic [11:0] pt, logic [15:0] nrm,
                                        logic [31:0] u, logic [31:0] v, logic nm);
        corner_t c;
        c = {pt, nrm, u, v, nm};
        corner_queue.insert(corner_queue.size(), c);
        corners_queued++;
    endfunction

    // Offset a coordinate around the tolerance boundary
    function automatic logic [31:0] near_value(logic [31:0] base);
        int off;
        case ($urandom_range(0, 5))
            0: off = 0;
            1: off = tol_reg - 1;
            2: off = 1 - tol_reg;
            3: off = tol_reg;
            4: off = -tol_reg;
            default: off = int'($urandom_range(0, 4 * tol_reg)) - 2 * tol_reg;
        endcase
        return base + off;
    endfunction

    function automatic void refresh_pool();
        int k;
        for (k = 0; k < POOL; k++)
        begin
            pool_point[k]  = 12'($urandom);
            pool_normal[k] = 16'($urandom);
            pool_u[k]      = $urandom;
            pool_v[k]      = $urandom;
        end
    endfunction

    // Mostly clustered corners on a few points, the rest fully random
    function automatic void push_random_corner();
        int k;
        if ($urandom_range(0, 99) < 15)
            push_corner(12'($urandom), 16'($urandom), $urandom, $urandom,
                        $urandom_range(0, 19) == 0);
        else
        begin
            k = $urandom_range(0, POOL - 1);
            push_corner(pool_point[k], pool_normal[k] + 16'($urandom_range(0, 2)),
                        near_value(pool_u[k]), near_value(pool_v[k]),
                        $urandom_range(0, 149) == 0);
        end
    endfunction

    task automatic write_tolerance(input logic [15:0] value);
        @(posedge clk);
        cfg_if.valid     <= 1'b1;
        cfg_if.tolerance <= value;
        do @(posedge clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        tol_reg = int'(value);
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endtask

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Drive corners from the pending queue and predict each accepted one
    always @(posedge clk)
    begin : corner_driver
        corner_t c;
        if (!rst_n)
            corner_if.valid <= 1'b0;
        else
        begin
            if (corner_if.valid && corner_if.ready)
            begin
                c = {corner_if.point_index, corner_if.normal_index, corner_if.tex_u,
                     corner_if.tex_v, corner_if.new_mesh};
                expected_vertices.insert(expected_vertices.size(), unify_corner(c));
                corners_accepted++;
            end
            if (!corner_if.valid || corner_if.ready)
            begin
                if (corner_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
                begin
                    c = corner_queue.pop_front();
                    corner_if.valid        <= 1'b1;
                    corner_if.point_index  <= c.point;
                    corner_if.normal_index <= c.normal;
                    corner_if.tex_u        <= c.u;
                    corner_if.tex_v        <= c.v;
                    corner_if.new_mesh     <= c.new_mesh;
                end
                else
                    corner_if.valid <= 1'b0;
            end
        end
    end

    // Check vertex items against the oldest expectation
    always @(posedge clk)
    begin : vertex_monitor
        vertex_t want;
        if (!rst_n)
            vertex_if.ready <= 1'b0;
        else
        begin
            if (vertex_if.valid && vertex_if.ready)
            begin
                if (expected_vertices.size() == 0)
                begin
                    $display("%0t: unexpected vertex item, actual index %0h",
                             $time, vertex_if.vertex_index);
                    error_count++;
                end
                else
                begin
                    want = expected_vertices.pop_front();
                    check_field("vertex_index", 32'(want.index), 32'(vertex_if.vertex_index));
                    check_field("is_new", 32'(want.is_new), 32'(vertex_if.is_new));
                    check_field("source_point", 32'(want.point), 32'(vertex_if.source_point));
                    check_field("source_normal", 32'(want.normal),
                                32'(vertex_if.source_normal));
                    check_field("out_u", want.u, vertex_if.out_u);
                    check_field("out_v", want.v, vertex_if.out_v);
                end
            end
            vertex_if.ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // Abort when no handshake completes for too long
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((corner_if.valid && corner_if.ready) || (vertex_if.valid && vertex_if.ready)
                || (cfg_if.valid && cfg_if.ready))
                stall_cycles <= 0;
            else
                stall_cycles <= stall_cycles + 1;
            if (stall_cycles >= STALL_LIMIT)
            begin
                $display("%0t: watchdog expired, %0d vertex items outstanding",
                         $time, expected_vertices.size());
                $display("status: fail");
                $finish;
            end
        end
    end

    // Reset, then run the phases
    initial
    begin : stimulus
        int send_plan [PHASES];
        int recv_plan [PHASES];
        int phase;
        int k;

        send_plan        = '{0, 69, 0, 25, 0, 25};
        recv_plan        = '{0, 0, 69, 25, 0, 25};
        rst_n            = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.tolerance = '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        for (phase = 0; phase < PHASES; phase++)
        begin
            // Set the tolerance while the block is idle
            case (phase)
                1: write_tolerance(16'd0);
                2: write_tolerance(16'hFFFF);
                3: write_tolerance(16'($urandom_range(2, 65534)));
                4: write_tolerance(16'd1);
                5: write_tolerance(16'($urandom_range(2, 4000)));
                default: ;
            endcase
            send_idle_pct  = send_plan[phase];
            recv_stall_pct = recv_plan[phase];

            // Directed corners under the reset tolerance
            if (phase == 0)
            begin
                push_corner(12'd0, 16'd0, 32'd0, 32'd0, 1'b1);
                push_corner(12'd0, 16'd0, 32'd654, -32'sd654, 1'b0);
                push_corner(12'd0, 16'd0, 32'd655, 32'd0, 1'b0);
                push_corner(12'd0, 16'd0, 32'd0, -32'sd655, 1'b0);
                push_corner(12'hFFF, 16'hFFFF, 32'h7FFFFFFF, 32'h80000000, 1'b0);
                push_corner(12'hFFF, 16'hFFFF, 32'h80000000, 32'h7FFFFFFF, 1'b0);
                push_corner(12'hFFF, 16'hFFFE, 32'h7FFFFFFF, 32'h80000000, 1'b0);
                push_corner(12'hFFF, 16'hFFFF, 32'h7FFFFF9B, 32'h80000064, 1'b0);
                // Fill every slot of one point, then overflow it twice
                for (k = 1; k <= SLOTS_PER + 1; k++)
                    push_corner(12'd7, 16'(k), 32'd0, 32'd0, 1'b0);
                push_corner(12'd7, 16'(SLOTS_PER + 1), 32'd0, 32'd0, 1'b0);
                push_corner(12'd7, 16'd3, 32'd0, 32'd0, 1'b0);
                // Restart the mesh: earlier slots no longer match
                push_corner(12'd7, 16'd3, 32'd0, 32'd0, 1'b1);
                push_corner(12'd0, 16'd0, 32'd0, 32'd0, 1'b0);
            end

            refresh_pool();
            for (k = 0; k < PHASE_ITEMS; k++)
                push_random_corner();

            // Drain before the next register write
            while (corners_accepted != corners_queued || expected_vertices.size() != 0)
                @(posedge clk);
            repeat (4) @(posedge clk);
        end

        repeat (8) @(posedge clk);
        if (expected_vertices.size() != 0)
        begin
            $display("%0t: %0d vertex items never arrived", $time, expected_vertices.size());
            error_count++;
        end

        $display("covered %0d corners over %0d tolerance settings and idle patterns",
                 corners_accepted, PHASES);
        $display("vertices: %0d recorded, %0d reused, %0d unrecorded; %0d mesh restarts",
                 n_recorded, n_reused, n_unrecorded, n_mesh);
        if (error_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
